[rtl/srts_pkg.sv]
// ----------------------------------------------------------------------------
// srts_pkg
// Types and constants shared by the sorted run table search unit.
// ----------------------------------------------------------------------------
package srts_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int KEY_W       = 32;
  localparam int BLK_W       = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  // function codes
  localparam logic [1:0] FN_INSERT = 2'd0;
  localparam logic [1:0] FN_FIND   = 2'd1;
  localparam logic [1:0] FN_BOUND  = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;

  typedef struct packed {
    logic [1:0]       func;
    logic [KEY_W-1:0] run_first_key;
    logic [KEY_W-1:0] run_last_key;
    logic [BLK_W-1:0] run_block;
    logic [KEY_W-1:0] search_key;
    logic             past_exact_hit;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [CNT_W-1:0] run_index;
    logic [BLK_W-1:0] found_block;
    logic [KEY_W-1:0] found_first_key;
    logic [KEY_W-1:0] found_last_key;
    logic [CNT_W-1:0] run_total;
  } out_item_t;

  // one table row as stored
  typedef struct packed {
    logic [KEY_W-1:0] first_key;
    logic [KEY_W-1:0] last_key;
    logic [BLK_W-1:0] block;
  } run_row_t;

  // controller to datapath
  typedef struct packed {
    logic latch;       // capture the accepted item
    logic insert;      // append run or flag full
    logic set_miss;    // result is a plain miss
    logic init_search; // open the search window
    logic issue_read;  // read the middle row
    logic step;        // narrow the window after a failed compare
    logic fin_hit;     // result from a containing run
    logic fin_miss;    // window empty: apply miss rules
    logic load_out;    // move result into output register
  } srts_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] func;
    logic       reject;     // find key outside level range or table empty
    logic       probe_live; // search window not empty
    logic       hit;        // row just read holds the key
  } srts_sts_t;

endpackage

[rtl/srts_dp.sv]
// ----------------------------------------------------------------------------
// srts_dp
// Run table memory, level range, search window and result registers.
// ----------------------------------------------------------------------------
module srts_dp import srts_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  srts_cmd_t        cmd,
  output srts_sts_t        sts,
  input  in_item_t         in_data,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_data,
  output out_item_t        out_data
);

  run_row_t mem [TABLE_DEPTH];

  in_item_t         item_r;
  run_row_t         rd_r;
  out_item_t        res_r;
  out_item_t        out_r;
  logic [CNT_W-1:0] cap_r;
  logic [CNT_W-1:0] run_count_r, run_count_nxt;
  logic [KEY_W-1:0] low_r, low_nxt;
  logic [KEY_W-1:0] high_r, high_nxt;
  logic [CNT_W-1:0] lo_r, lo_nxt;
  logic [CNT_W-1:0] hip_r, hip_nxt;   // one past the upper bound
  logic [IDX_W-1:0] mid_r, mid_nxt;
  logic             above_r, above_nxt;
  logic             below_r, below_nxt;
  out_item_t        res_nxt;

  logic [CNT_W:0]   mid_sum;
  logic [CNT_W-1:0] lim;
  logic [CNT_W-1:0] mid_ext;
  logic [CNT_W-1:0] mid_inc;
  logic             cmp_above;
  logic             cmp_below;
  logic             full;
  logic [KEY_W-1:0] lo_a, hi_a;

  assign mid_sum   = {1'b0, lo_r} + {1'b0, hip_r} - (CNT_W+1)'(1);
  assign mid_ext   = {1'b0, mid_r};
  assign mid_inc   = mid_ext + CNT_W'(1);
  assign lim       = (cap_r < DEPTH_CNT) ? cap_r : DEPTH_CNT;
  assign full      = run_count_r >= lim;
  assign cmp_above = rd_r.first_key > item_r.search_key;
  assign cmp_below = rd_r.last_key < item_r.search_key;

  assign sts.func       = item_r.func;
  assign sts.reject     = (run_count_r == '0) || (item_r.search_key < low_r) ||
                          (item_r.search_key > high_r);
  assign sts.probe_live = lo_r < hip_r;
  assign sts.hit        = !cmp_above && !cmp_below;

  assign out_data = out_r;

  // widen the level range with both keys of the new run
  always_comb begin
    lo_a = (item_r.run_first_key < item_r.run_last_key) ?
           item_r.run_first_key : item_r.run_last_key;
    hi_a = (item_r.run_first_key > item_r.run_last_key) ?
           item_r.run_first_key : item_r.run_last_key;
  end

  always_comb begin
    run_count_nxt = run_count_r;
    low_nxt       = low_r;
    high_nxt      = high_r;
    lo_nxt        = lo_r;
    hip_nxt       = hip_r;
    mid_nxt       = mid_r;
    above_nxt     = above_r;
    below_nxt     = below_r;
    res_nxt       = res_r;

    if (cmd.insert) begin
      res_nxt           = '0;
      res_nxt.run_index = run_count_r;
      if (full) begin
        res_nxt.status    = ST_FULL;
        res_nxt.run_total = run_count_r;
      end else begin
        res_nxt.status    = ST_OK;
        run_count_nxt     = run_count_r + CNT_W'(1);
        res_nxt.run_total = run_count_r + CNT_W'(1);
        if (lo_a < low_r)  low_nxt  = lo_a;
        if (hi_a > high_r) high_nxt = hi_a;
      end
    end

    if (cmd.set_miss) begin
      res_nxt           = '0;
      res_nxt.status    = ST_MISS;
      res_nxt.run_total = run_count_r;
    end

    if (cmd.init_search) begin
      lo_nxt    = '0;
      hip_nxt   = run_count_r;
      mid_nxt   = '0;
      above_nxt = 1'b0;
      below_nxt = 1'b0;
    end

    if (cmd.issue_read) begin
      mid_nxt = mid_sum[IDX_W:1];
    end

    if (cmd.step) begin
      above_nxt = cmp_above;
      below_nxt = cmp_below;
      if (cmp_above) hip_nxt = mid_ext;
      else           lo_nxt  = mid_inc;
    end

    if (cmd.fin_hit) begin
      res_nxt           = '0;
      res_nxt.status    = ST_OK;
      res_nxt.run_total = run_count_r;
      if (item_r.func == FN_FIND) begin
        res_nxt.run_index       = mid_ext;
        res_nxt.found_block     = rd_r.block;
        res_nxt.found_first_key = rd_r.first_key;
        res_nxt.found_last_key  = rd_r.last_key;
      end else begin
        res_nxt.run_index = item_r.past_exact_hit ? mid_inc : mid_ext;
      end
    end

    if (cmd.fin_miss) begin
      res_nxt           = '0;
      res_nxt.status    = ST_MISS;
      res_nxt.run_total = run_count_r;
      if (item_r.func == FN_BOUND) begin
        if (above_r) begin
          res_nxt.status    = ST_OK;
          res_nxt.run_index = mid_ext;
        end else if (below_r && (mid_inc < run_count_r)) begin
          res_nxt.status    = ST_OK;
          res_nxt.run_index = mid_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_count_r <= '0;
      low_r       <= '1;
      high_r      <= '0;
      cap_r       <= DEPTH_CNT;
    end else begin
      run_count_r <= run_count_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
      if (cfg_we) cap_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch)    item_r <= in_data;
    if (cmd.load_out) out_r  <= res_r;
    lo_r    <= lo_nxt;
    hip_r   <= hip_nxt;
    mid_r   <= mid_nxt;
    above_r <= above_nxt;
    below_r <= below_nxt;
    res_r   <= res_nxt;
  end

  // table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.insert && !full) begin
      mem[run_count_r[IDX_W-1:0]] <= '{first_key: item_r.run_first_key,
                                       last_key:  item_r.run_last_key,
                                       block:     item_r.run_block};
    end
    if (cmd.issue_read) rd_r <= mem[mid_sum[IDX_W:1]];
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    run_count_r <= DEPTH_CNT)
    else $error("run count past table depth");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.insert |=> run_count_r == $past(run_count_r))
    else $error("run count moved without an insert");

  a_read_live: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue_read |-> lo_r < hip_r)
    else $error("row read with an empty search window");

  a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
    run_count_r != '0 |-> low_r <= high_r)
    else $error("level range inverted");

endmodule

[rtl/srts_ctrl.sv]
// ----------------------------------------------------------------------------
// srts_ctrl
// Sequencer for insert, find and bound search; owns the output valid.
// ----------------------------------------------------------------------------
module srts_ctrl import srts_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  srts_sts_t sts,
  output srts_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_PROBE = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.func)
          FN_INSERT: begin
            cmd.insert = 1'b1;
            state_nxt  = S_DONE;
          end
          FN_FIND: begin
            if (sts.reject) begin
              cmd.set_miss = 1'b1;
              state_nxt    = S_DONE;
            end else begin
              cmd.init_search = 1'b1;
              state_nxt       = S_PROBE;
            end
          end
          FN_BOUND: begin
            cmd.init_search = 1'b1;
            state_nxt       = S_PROBE;
          end
          default: begin
            cmd.set_miss = 1'b1;
            state_nxt    = S_DONE;
          end
        endcase
      end
      S_PROBE: begin
        if (sts.probe_live) begin
          cmd.issue_read = 1'b1;
          state_nxt      = S_CMP;
        end else begin
          cmd.fin_miss = 1'b1;
          state_nxt    = S_DONE;
        end
      end
      S_CMP: begin
        if (sts.hit) begin
          cmd.fin_hit = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_PROBE;
        end
      end
      S_DONE: begin
        // hold until the output register can take the result
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out)     out_valid_nxt = 1'b1;
    else if (!out_stall)  out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> slot_free)
    else $error("result loaded over an item still waiting");

  a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r && state_r == S_IDLE)
    else $error("loaded result not presented");

  a_cmp_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CMP |-> $past(cmd.issue_read))
    else $error("compare without a row read");

endmodule

[rtl/sorted_run_table_search_unit.sv]
// ----------------------------------------------------------------------------
// sorted_run_table_search_unit
// Run table of one storage level: append runs, find the run holding a key,
// and lower-bound search, over a binary search of the stored runs.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  in_      input      in_valid/in_stall  in_item_t  (func, run, search key)
//  out_     output     out_valid/out_stall out_item_t (status, index, run)
//  cfg_     input      cfg_valid/cfg_ready level_capacity, 11 bits
//
//  Insert, func 3 and a find outside the level range go from dispatch straight
//  to the result; any other lookup alternates probe and compare states, with
//  up to 11 probes at 1024 runs. Each probe is one read of the table memory's
//  registered read port.
//  rst_n is synchronous: it empties the table and sets capacity to 1024;
//  table rows need no clearing. A stalled result sits in the output register
//  while the next item is taken and searched.
// ----------------------------------------------------------------------------
module sorted_run_table_search_unit import srts_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data
);

  srts_cmd_t cmd;
  srts_sts_t sts;

  assign cfg_ready = 1'b1;

  srts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  srts_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_data),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .out_data (out_data)
  );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for sorted_run_table_search_unit. It appends runs, finds the run
// holding a key and runs bound searches under several level capacities, while
// both sides idle at random. A local mirror of the run table works out every
// result, and each result from the block is checked against it in order.
// ----------------------------------------------------------------------------
module tb_top;
  import srts_pkg::*;

  localparam logic [1:0] FN_NOP       = 2'd3;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         DRAIN_CYCLES = 40;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_stall;
  out_item_t        out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data;

  // mirror of the run table
  logic [KEY_W-1:0] run_first [TABLE_DEPTH];
  logic [KEY_W-1:0] run_last  [TABLE_DEPTH];
  logic [BLK_W-1:0] run_blk   [TABLE_DEPTH];
  int unsigned      runs_held;
  logic [KEY_W-1:0] level_low;
  logic [KEY_W-1:0] level_high;
  logic [CNT_W-1:0] capacity;
  longint unsigned  key_cursor;

  out_item_t        table_results_due[$];
  int unsigned      error_count = 0;
  bit               no_idle = 1'b0;
  bit               hold_req = 1'b0;

  sorted_run_table_search_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Binary search over the held runs; on a miss leave the last probe in pos.
  function automatic bit search_runs(input logic [KEY_W-1:0] key, output int pos,
                                     output bit above, output bit below);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = int'(runs_held) - 1;
    mid = 0;
    above = 1'b0;
    below = 1'b0;
    pos = 0;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      above = run_first[mid] > key;
      below = run_last[mid] < key;
      if (!above && !below) begin
        pos = mid;
        return 1'b1;
      end
      if (above) hi = mid - 1;
      else lo = mid + 1;
    end
    pos = mid;
    return 1'b0;
  endfunction

  // Apply one item to the mirror and return the result the block must give.
  function automatic out_item_t run_table_step(input in_item_t it);
    out_item_t r;
    int        pos;
    bit        above;
    bit        below;
    bit        hit;
    int        limit;
    r = '0;
    r.status = ST_MISS;
    limit = (int'(capacity) < TABLE_DEPTH) ? int'(capacity) : TABLE_DEPTH;
    case (it.func)
      FN_INSERT: begin
        if (int'(runs_held) >= limit) begin
          r.status = ST_FULL;
          r.run_index = CNT_W'(runs_held);
        end else begin
          run_first[runs_held] = it.run_first_key;
          run_last[runs_held] = it.run_last_key;
          run_blk[runs_held] = it.run_block;
          if (it.run_first_key < level_low) level_low = it.run_first_key;
          if (it.run_first_key > level_high) level_high = it.run_first_key;
          if (it.run_last_key < level_low) level_low = it.run_last_key;
          if (it.run_last_key > level_high) level_high = it.run_last_key;
          r.status = ST_OK;
          r.run_index = CNT_W'(runs_held);
          runs_held++;
        end
      end
      FN_FIND: begin
        hit = search_runs(it.search_key, pos, above, below);
        if (runs_held != 0 && it.search_key >= level_low && it.search_key <= level_high
            && hit) begin
          r.status = ST_OK;
          r.run_index = CNT_W'(pos);
          r.found_block = run_blk[pos];
          r.found_first_key = run_first[pos];
          r.found_last_key = run_last[pos];
        end
      end
      FN_BOUND: begin
        hit = search_runs(it.search_key, pos, above, below);
        if (hit) begin
          r.status = ST_OK;
          r.run_index = CNT_W'(pos + (it.past_exact_hit ? 1 : 0));
        end else if (above) begin
          r.status = ST_OK;
          r.run_index = CNT_W'(pos);
        end else if (below && pos + 1 < int'(runs_held)) begin
          r.status = ST_OK;
          r.run_index = CNT_W'(pos + 1);
        end
      end
      default: ;
    endcase
    r.run_total = CNT_W'(runs_held);
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned sel;
    if (no_idle) return 0;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 88) return $urandom_range(1, 3);
    if (sel < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_item_t noise_item();
    in_item_t it;
    it.func = 2'($urandom_range(0, 3));
    it.run_first_key = $urandom;
    it.run_last_key = $urandom;
    it.run_block = $urandom;
    it.search_key = $urandom;
    it.past_exact_hit = 1'($urandom);
    return it;
  endfunction

  function automatic in_item_t run_item(input logic [KEY_W-1:0] first_key,
                                        input logic [KEY_W-1:0] last_key,
                                        input logic [BLK_W-1:0] blk);
    in_item_t it;
    it = noise_item();
    it.func = FN_INSERT;
    it.run_first_key = first_key;
    it.run_last_key = last_key;
    it.run_block = blk;
    return it;
  endfunction

  function automatic in_item_t lookup_item(input logic [1:0] fn, input logic [KEY_W-1:0] key,
                                           input logic past);
    in_item_t it;
    it = noise_item();
    it.func = fn;
    it.search_key = key;
    it.past_exact_hit = past;
    return it;
  endfunction

  // Next run above the cursor; a broken one is reversed or overlaps the last run.
  function automatic in_item_t next_run_item(input bit broken);
    longint unsigned first_key;
    longint unsigned last_key;
    longint unsigned swap_key;
    first_key = key_cursor + $urandom_range(1, 1 << 22);
    last_key = first_key + $urandom_range(0, 1 << 21);
    if (broken) begin
      if ($urandom_range(0, 1) == 0) begin
        swap_key = first_key;
        first_key = last_key;
        last_key = swap_key;
      end else if (key_cursor > 8) begin
        first_key = key_cursor - $urandom_range(0, 8);
      end
    end
    key_cursor = (first_key > last_key) ? first_key : last_key;
    return run_item(KEY_W'(first_key), KEY_W'(last_key), $urandom);
  endfunction

  // Aim lookups at run edges, run interiors, gaps and the level bounds.
  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned     sel;
    int unsigned     row;
    longint unsigned lo_k;
    longint unsigned hi_k;
    sel = $urandom_range(0, 99);
    if (runs_held == 0 || sel >= 85) return $urandom;
    row = $urandom_range(0, runs_held - 1);
    lo_k = run_first[row];
    hi_k = run_last[row];
    if (sel < 10) return run_first[row];
    if (sel < 20) return run_last[row];
    if (sel < 45) begin
      if (hi_k < lo_k) return run_first[row];
      return KEY_W'(lo_k + ({$urandom, $urandom} % (hi_k - lo_k + 1)));
    end
    if (sel < 65) return run_last[row] + KEY_W'($urandom_range(1, 16));
    if (sel < 75) return level_low - KEY_W'($urandom_range(0, 2));
    return level_high + KEY_W'($urandom_range(0, 2));
  endfunction

  function automatic in_item_t random_item(input int unsigned insert_pct);
    in_item_t    it;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < insert_pct) return next_run_item($urandom_range(0, 99) < 4);
    it = noise_item();
    sel = $urandom_range(0, 99);
    it.func = (sel < 47) ? FN_FIND : (sel < 97) ? FN_BOUND : FN_NOP;
    it.search_key = pick_key();
    return it;
  endfunction

  // Offer one item, hold it until taken, then record what it must return.
  task automatic send_item(input in_item_t it);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    table_results_due.push_back(run_table_step(it));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (table_results_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CNT_W-1:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    capacity = value;
  endtask

  task automatic test_empty_table();
    send_item(lookup_item(FN_FIND, '0, 1'b0));
    send_item(lookup_item(FN_FIND, '1, 1'b1));
    send_item(lookup_item(FN_BOUND, '0, 1'b0));
    send_item(lookup_item(FN_BOUND, '1, 1'b1));
    send_item(lookup_item(FN_NOP, $urandom, 1'b1));
  endtask

  task automatic test_zero_capacity();
    write_capacity('0);
    send_item(run_item('1, '0, '1));
    send_item(run_item('0, '1, '0));
  endtask

  task automatic test_single_run();
    write_capacity(11'd1);
    send_item(run_item(32'h0000_0000, 32'h0000_0100, '0));
    key_cursor = 32'h0000_0100;
    send_item(run_item(32'h0000_0200, 32'h0000_0300, '1));
    send_item(lookup_item(FN_FIND, 32'h0000_0000, 1'b0));
    send_item(lookup_item(FN_FIND, 32'h0000_0101, 1'b0));
    send_item(lookup_item(FN_BOUND, 32'h0000_0200, 1'b0));
    send_item(lookup_item(FN_BOUND, 32'h0000_0000, 1'b1));
  endtask

  // Capacity above the table depth clamps; exercise every bound miss rule.
  task automatic test_bound_miss_rules();
    write_capacity('1);
    send_item(run_item(32'h0000_1000, 32'h0000_1fff, '1));
    send_item(run_item(32'h0000_3000, 32'h0000_3fff, '0));
    send_item(run_item(32'h0000_5000, 32'h0000_5fff, $urandom));
    key_cursor = 32'h0000_5fff;
    send_item(lookup_item(FN_FIND, 32'h0000_2000, 1'b0));
    send_item(lookup_item(FN_BOUND, 32'h0000_2000, 1'b0));
    send_item(lookup_item(FN_BOUND, 32'h0000_0800, 1'b1));
    send_item(lookup_item(FN_FIND, 32'h0000_5000, 1'b1));
    send_item(lookup_item(FN_BOUND, 32'h0000_5000, 1'b1));
    send_item(lookup_item(FN_BOUND, 32'h0000_6000, 1'b0));
  endtask

  task automatic test_random_traffic();
    int unsigned phase;
    int unsigned n;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_capacity(CNT_W'(runs_held + $urandom_range(50, 150)));
        1: write_capacity(11'd1);
        2: write_capacity(CNT_W'(runs_held + $urandom_range(150, 300)));
        default: write_capacity('1);
      endcase
      // back up the result side long enough to fill the block
      hold_req = (phase == 1);
      for (n = 0; n < 125; n++) begin
        no_idle = (phase == 2 && n < 100);
        send_item(random_item(phase == 1 ? 30 : 70));
      end
      no_idle = 1'b0;
    end
  endtask

  task automatic test_full_table();
    int unsigned n;
    write_capacity(DEPTH_CNT);
    while (runs_held < TABLE_DEPTH) begin
      if (runs_held == TABLE_DEPTH - 1)
        send_item(run_item(KEY_W'(key_cursor + 1), '1, $urandom));
      else
        send_item(random_item(95));
    end
    for (n = 0; n < 40; n++) send_item(random_item(20));
  endtask

  initial begin : result_stall
    int unsigned span;
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        span = HOLD_CYCLES;
      end else if (no_idle) begin
        out_stall <= 1'b0;
        span = 1;
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        span = pick_gap() + 1;
      end
      repeat (span) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (table_results_due.size() == 0) begin
        error_count++;
        if (error_count <= 10) $display("unexpected result item: %p", out_data);
      end else begin
        want = table_results_due.pop_front();
        if (out_data.status !== want.status || out_data.run_index !== want.run_index ||
            out_data.found_block !== want.found_block ||
            out_data.found_first_key !== want.found_first_key ||
            out_data.found_last_key !== want.found_last_key ||
            out_data.run_total !== want.run_total) begin
          error_count++;
          if (error_count <= 10) begin
            $write("mismatch exp/got: status %0d/%0d index %0d/%0d block %h/%h",
                   want.status, out_data.status, want.run_index, out_data.run_index,
                   want.found_block, out_data.found_block);
            $display(" first %h/%h last %h/%h total %0d/%0d",
                     want.found_first_key, out_data.found_first_key,
                     want.found_last_key, out_data.found_last_key,
                     want.run_total, out_data.run_total);
          end
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    runs_held = 0;
    level_low = '1;
    level_high = '0;
    capacity = DEPTH_CNT;
    key_cursor = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    test_zero_capacity();
    test_single_run();
    test_bound_miss_rules();
    test_random_traffic();
    test_full_table();
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #6_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
